// ===== rtl/core/dmrc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmrc_pkg
// Shared widths, op codes and the cache entry layout for the direct-mapped
// result cache.
// ----------------------------------------------------------------------------
package dmrc_pkg;

  localparam int ENTRIES_DEFAULT = 1024;

  localparam int KEY_W      = 64;
  localparam int FRAME_IN_W = 25;
  localparam int FRAME_W    = 24;
  localparam int COST_W     = 32;
  localparam int CNT_W      = 32;
  localparam int OP_W       = 2;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [FRAME_W-1:0] frame;
    logic [COST_W-1:0]  cost;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/core/dmrc_ram.sv =====
// ----------------------------------------------------------------------------
// dmrc_ram
// Generic single-port synchronous RAM, one write or read per cycle,
// registered read data.
// ----------------------------------------------------------------------------
module dmrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/dmrc_slot.sv =====
// ----------------------------------------------------------------------------
// dmrc_slot
// Slot index unit: key modulo ENTRIES. Power-of-two sizes register the low
// bits; other sizes sum the per-byte residues of the key, then reduce the
// registered sum by compare and subtract against shifted copies of ENTRIES.
// ----------------------------------------------------------------------------
module dmrc_slot import dmrc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [KEY_W-1:0]           key,
  output logic                       done,
  output logic [$clog2(ENTRIES)-1:0] slot
);

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam bit IS_POW2 = (ENTRIES & (ENTRIES - 1)) == 0;

  generate
    if (IS_POW2) begin : g_pow2
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          slot <= key[IDX_W-1:0];
        end
      end
    end else begin : g_fold
      // byte residues sum below 2^11 * ENTRIES: subtracting shifted copies of ENTRIES finishes it
      localparam int CHUNKS = KEY_W / 8;
      localparam int ACC_W  = IDX_W + 11;
      localparam logic [ACC_W-1:0] MODULUS    = ACC_W'(ENTRIES);
      localparam logic [1:0]       LAST_PHASE = 2'd2;

      logic             running;
      logic [1:0]       phase;
      logic [3:0]       top_shift;
      logic [ACC_W-1:0] acc;
      logic [ACC_W-1:0] fold;
      logic [ACC_W-1:0] red;
      logic [ACC_W-1:0] part [CHUNKS];

      for (genvar g = 0; g < CHUNKS; g++) begin : g_part
        localparam longint unsigned WEIGHT = (64'd1 << (8 * g)) % 64'(ENTRIES);
        assign part[g] = ACC_W'(key[8*g +: 8]) * ACC_W'(WEIGHT);
      end

      always_comb begin
        fold = '0;
        for (int i = 0; i < CHUNKS; i++) begin
          fold = fold + part[i];
        end
      end

      always_comb begin
        case (phase)
          2'd0: begin
            top_shift = 4'd11;
          end
          2'd1: begin
            top_shift = 4'd7;
          end
          default: begin
            top_shift = 4'd3;
          end
        endcase
        red = acc;
        for (int s = 0; s < 4; s++) begin
          if (red >= (MODULUS << (top_shift - 4'(s)))) begin
            red = red - (MODULUS << (top_shift - 4'(s)));
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          running <= 1'b0;
          done    <= 1'b0;
          phase   <= '0;
        end else begin
          done <= 1'b0;
          if (start && !running) begin
            running <= 1'b1;
            phase   <= '0;
          end else if (running) begin
            phase <= phase + 1'b1;
            if (phase == LAST_PHASE) begin
              running <= 1'b0;
              done    <= 1'b1;
            end
          end
        end
        if (start && !running) begin
          acc <= fold;
        end else if (running) begin
          acc <= red;
        end
        if (running && phase == LAST_PHASE) begin
          slot <= red[IDX_W-1:0];
        end
      end
    end
  endgenerate

endmodule

// ===== rtl/core/direct_mapped_result_cache_top.sv =====
// ----------------------------------------------------------------------------
// direct_mapped_result_cache_top
// Direct-mapped cache of search results keyed on a 64-bit hash, held in one
// synchronous RAM of key, frame, cost and valid per slot.
// ----------------------------------------------------------------------------
// One item at a time. An item is taken when start is high and busy is low;
// its result appears on the result ports for exactly one cycle with done
// high, and the receiver cannot stall it. With ENTRIES a power of two a store
// gives its result after the slot register and the RAM write, and a lookup
// after the slot register and the registered RAM read; other sizes first
// reduce the folded key remainder in registered phases. A clear sweeps every
// slot of the RAM, one per cycle, and gives its result when the sweep ends.
// After reset the same sweep runs with busy high. An unused op code gives its
// result in the next cycle and changes nothing.
// ----------------------------------------------------------------------------
module direct_mapped_result_cache_top import dmrc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [OP_W-1:0]              opcode,
  input  logic [KEY_W-1:0]             key,
  input  logic signed [FRAME_IN_W-1:0] frame_in,
  input  logic [COST_W-1:0]            cost_in,
  output logic                         done,
  output logic                         hit,
  output logic [FRAME_W-1:0]           frame_out,
  output logic [COST_W-1:0]            cost_out,
  output logic [CNT_W-1:0]             hit_total,
  output logic [CNT_W-1:0]             miss_total
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [4:0] {
    ST_SWEEP = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_HASH  = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_SPARE = 5'b10000
  } state_t;

  state_t state;

  logic [OP_W-1:0]       op_r;
  logic [KEY_W-1:0]      key_r;
  logic [FRAME_IN_W-1:0] frame_r;
  logic [COST_W-1:0]     cost_r;
  logic [IDX_W-1:0]      slot_r;
  logic [IDX_W-1:0]      sweep_addr;
  logic                  clear_pending;
  logic [CNT_W-1:0]      hit_counter;
  logic [CNT_W-1:0]      miss_counter;

  logic                  accept;
  logic                  slot_start;
  logic                  slot_done;
  logic [IDX_W-1:0]      slot_idx;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_addr;
  entry_t                ram_wdata;
  entry_t                ram_rdata;
  logic                  lookup_hit;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign slot_start = accept && (opcode == OP_LOOKUP || opcode == OP_STORE);
  assign hit_total  = hit_counter;
  assign miss_total = miss_counter;
  assign lookup_hit = ram_rdata.valid && (ram_rdata.key == key_r);

  dmrc_slot #(
    .ENTRIES (ENTRIES)
  ) u_slot (
    .clk   (clk),
    .rst   (rst),
    .start (slot_start),
    .key   (key),
    .done  (slot_done),
    .slot  (slot_idx)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = slot_idx;
    ram_wdata = '0;
    case (state)
      ST_SWEEP: begin
        ram_we   = 1'b1;
        ram_addr = sweep_addr;
      end
      ST_HASH: begin
        ram_we          = slot_done && (op_r == OP_STORE);
        ram_wdata.valid = !frame_r[FRAME_IN_W-1];
        ram_wdata.key   = key_r;
        ram_wdata.frame = frame_r[FRAME_IN_W-1] ? '0 : frame_r[FRAME_W-1:0];
        ram_wdata.cost  = cost_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  dmrc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      sweep_addr    <= '0;
      clear_pending <= 1'b0;
      hit_counter   <= '0;
      miss_counter  <= '0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == LAST_IDX) begin
            state         <= ST_IDLE;
            done          <= clear_pending;
            clear_pending <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (opcode == OP_CLEAR) begin
              state         <= ST_SWEEP;
              sweep_addr    <= '0;
              clear_pending <= 1'b1;
              hit_counter   <= '0;
              miss_counter  <= '0;
            end else if (slot_start) begin
              state <= ST_HASH;
            end else begin
              done <= 1'b1;
            end
          end
        end
        ST_HASH: begin
          if (slot_done) begin
            if (op_r == OP_STORE) begin
              state <= ST_IDLE;
              done  <= 1'b1;
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          state <= ST_IDLE;
          done  <= 1'b1;
          if (lookup_hit) begin
            if (hit_counter != '1) begin
              hit_counter <= hit_counter + 1'b1;
            end
          end else if (miss_counter != '1) begin
            miss_counter <= miss_counter + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= opcode;
      key_r   <= key;
      frame_r <= frame_in;
      cost_r  <= cost_in;
    end
    if (state == ST_HASH && slot_done) begin
      slot_r <= slot_idx;
    end
    if (state == ST_CHECK && lookup_hit) begin
      hit       <= 1'b1;
      frame_out <= ram_rdata.frame;
      cost_out  <= ram_rdata.cost;
    end else begin
      hit       <= 1'b0;
      frame_out <= '0;
      cost_out  <= '0;
    end
  end

  a_check_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |=> done)
    else $error("lookup check did not produce a result");

  a_ram_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_SWEEP || state == ST_HASH))
    else $error("RAM written outside sweep or store");

  a_hit_counts: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (hit_total != '0))
    else $error("hit reported with zero hit count");

  a_counter_drop: assert property (@(posedge clk) disable iff (rst)
    (hit_total < $past(hit_total)) |-> (state == ST_SWEEP))
    else $error("hit counter dropped without a clear");

  a_slot_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> (slot_r == $past(slot_idx)))
    else $error("slot changed between read and check");

endmodule

// ===== sim/tb_direct_mapped_result_cache_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_direct_mapped_result_cache_top
// Self-checking bench for the direct-mapped result cache. A shadow copy of the
// slots and hit/miss counters predicts every response. Directed lookups,
// stores and clears run first, then random traffic built from a pool of
// stored keys so that hits, evictions and invalid stores all occur.
// ----------------------------------------------------------------------------
module tb_direct_mapped_result_cache_top;
  import dmrc_pkg::*;

  localparam int SLOTS = ENTRIES_DEFAULT;
  localparam logic [KEY_W-1:0] SLOT_MASK = KEY_W'(SLOTS - 1);
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int KEY_POOL_MAX = 64;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic [COST_W-1:0]  cost;
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   misses;
  } cache_response_t;

  class result_cache_shadow;
    logic [KEY_W-1:0]   slot_key   [SLOTS];
    logic [FRAME_W-1:0] slot_frame [SLOTS];
    logic [COST_W-1:0]  slot_cost  [SLOTS];
    bit                 slot_valid [SLOTS];
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   misses;
    cache_response_t    due[$];
    int                 errors;

    function new();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      hits = '0;
      misses = '0;
      errors = 0;
    endfunction

    function void apply_command(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                logic [FRAME_IN_W-1:0] fr, logic [COST_W-1:0] c);
      cache_response_t r;
      int unsigned s;
      r = '0;
      s = int'(k % SLOTS);
      case (op)
        OP_LOOKUP: begin
          if (slot_valid[s] && slot_key[s] == k) begin
            r.hit = 1'b1;
            r.frame = slot_frame[s];
            r.cost = slot_cost[s];
            if (hits != '1) hits = hits + 1;
          end else if (misses != '1) begin
            misses = misses + 1;
          end
        end
        OP_STORE: begin
          slot_key[s] = k;
          slot_cost[s] = c;
          slot_valid[s] = !fr[FRAME_IN_W-1];
          slot_frame[s] = fr[FRAME_IN_W-1] ? '0 : fr[FRAME_W-1:0];
        end
        OP_CLEAR: begin
          foreach (slot_valid[i]) slot_valid[i] = 1'b0;
          hits = '0;
          misses = '0;
        end
        default: ;
      endcase
      r.hits = hits;
      r.misses = misses;
      due.push_back(r);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void compare_response(cache_response_t got);
      cache_response_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: response with no item pending, actual %h", $time, got);
        return;
      end
      want = due.pop_front();
      check_field("hit", 64'(want.hit), 64'(got.hit));
      check_field("frame_out", 64'(want.frame), 64'(got.frame));
      check_field("cost_out", 64'(want.cost), 64'(got.cost));
      check_field("hit_total", 64'(want.hits), 64'(got.hits));
      check_field("miss_total", 64'(want.misses), 64'(got.misses));
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic [OP_W-1:0]              opcode = OP_LOOKUP;
  logic [KEY_W-1:0]             key = '0;
  logic signed [FRAME_IN_W-1:0] frame_in = '0;
  logic [COST_W-1:0]            cost_in = '0;
  logic                         busy;
  logic                         done;
  logic                         hit;
  logic [FRAME_W-1:0]           frame_out;
  logic [COST_W-1:0]            cost_out;
  logic [CNT_W-1:0]             hit_total;
  logic [CNT_W-1:0]             miss_total;

  result_cache_shadow book = new();
  logic [KEY_W-1:0] stored_keys[$];

  direct_mapped_result_cache_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .key(key), .frame_in(frame_in), .cost_in(cost_in),
    .done(done), .hit(hit), .frame_out(frame_out), .cost_out(cost_out),
    .hit_total(hit_total), .miss_total(miss_total)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      book.compare_response({hit, frame_out, cost_out, hit_total, miss_total});
    end
  end

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_W-1:0] pick_stored_key();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  // different key, same slot
  function automatic logic [KEY_W-1:0] alias_key(logic [KEY_W-1:0] base);
    return (rand_key() & ~SLOT_MASK) | (base & SLOT_MASK);
  endfunction

  task automatic issue(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                       logic [FRAME_IN_W-1:0] fr, logic [COST_W-1:0] c);
    start <= 1'b1;
    opcode <= op;
    key <= k;
    frame_in <= fr;
    cost_in <= c;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    book.apply_command(op, k, fr, c);
    if (op == OP_STORE) begin
      stored_keys.push_back(k);
      if (stored_keys.size() > KEY_POOL_MAX) void'(stored_keys.pop_front());
    end
  endtask

  task automatic run_directed();
    logic [KEY_W-1:0] far_key;
    far_key = 64'h8000_0000_0000_0005;
    issue(OP_STORE, '0, '0, '0);
    issue(OP_LOOKUP, '0, '1, '1);
    issue(OP_STORE, '1, 25'h0FF_FFFF, '1);
    issue(OP_LOOKUP, '1, '0, '0);
    issue(OP_LOOKUP, 64'h3FF, '0, '0);
    issue(OP_STORE, far_key, '1, 32'hA5A5_5A5A);
    issue(OP_LOOKUP, far_key, '0, '0);
    issue(OP_STORE, 64'h5, 25'h100_0000, 32'h1234_5678);
    issue(OP_LOOKUP, 64'h5, '0, '0);
    issue(OP_STORE, 64'h5, 25'd12345, 32'h5A5A_A5A5);
    issue(OP_LOOKUP, 64'h5, '0, '0);
    issue(OP_LOOKUP, far_key, '0, '0);
    issue(OP_UNUSED, '1, 25'd7, 32'hDEAD_BEEF);
    issue(OP_LOOKUP, '1, '0, '0);
    issue(OP_STORE, 64'h1234_5678_9ABC_D3FF, 25'h0AA_AAAA, 32'h5555_AAAA);
    issue(OP_LOOKUP, '1, '0, '0);
    issue(OP_LOOKUP, 64'h1234_5678_9ABC_D3FF, '0, '0);
    issue(OP_CLEAR, '1, '1, '1);
    issue(OP_LOOKUP, '0, '0, '0);
    issue(OP_STORE, '0, 25'd1, 32'h1);
    issue(OP_LOOKUP, '0, '0, '0);
  endtask

  task automatic run_random(int count, int idle_pct);
    int unsigned pick;
    logic [OP_W-1:0] op;
    logic [KEY_W-1:0] k;
    logic [FRAME_IN_W-1:0] fr;
    repeat (count) begin
      while ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end
      pick = $urandom_range(0, 199);
      if (pick < 2) op = OP_CLEAR;
      else if (pick < 6) op = OP_UNUSED;
      else if (pick < 86) op = OP_STORE;
      else op = OP_LOOKUP;
      fr = 25'($urandom);
      if (op == OP_STORE) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) k = pick_stored_key();
        else if (pick < 6) k = alias_key(pick_stored_key());
        else k = rand_key();
        pick = $urandom_range(0, 19);
        if (pick == 0) fr = 25'h0FF_FFFF;
        else if (pick == 1) fr = '0;
        else if (pick < 5) fr[FRAME_IN_W-1] = 1'b1;
        else fr[FRAME_IN_W-1] = 1'b0;
      end else if (op == OP_LOOKUP) begin
        k = ($urandom_range(0, 99) < 65) ? pick_stored_key() : alias_key(pick_stored_key());
      end else begin
        k = rand_key();
      end
      issue(op, k, fr, $urandom);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(400, 9);
    run_random(400, 79);
    run_random(400, 0);
    start <= 1'b0;
    while (book.due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.errors == 0) begin
      $display("direct_mapped_result_cache_top regression: pass");
    end else begin
      $display("direct_mapped_result_cache_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("direct_mapped_result_cache_top regression: fail");
    $finish;
  end

endmodule

// ===== direct_mapped_result_cache_top.f =====
rtl/core/dmrc_pkg.sv
rtl/core/dmrc_ram.sv
rtl/core/dmrc_slot.sv
rtl/core/direct_mapped_result_cache_top.sv
sim/tb_direct_mapped_result_cache_top.sv
